/* rtl/stwd_pkg.sv */
package stwd_pkg;

    localparam int MAX_EVENTS = 64;
    localparam int ADDR_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

    localparam int POS_W   = 24;
    localparam int TIME_W  = 40;
    localparam int MAG_W   = 11;
    localparam int IDX_W   = 6;
    localparam int WGT_W   = 16;
    localparam int R2_W    = 32;
    localparam int DUR_W   = 21;
    localparam int SQ_W    = 2 * (POS_W + 1);
    localparam int D2_W    = SQ_W + 2;
    localparam int NUM_W   = TIME_W + 12;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 2;
    localparam int ROM_DEPTH = 1 << MAG_W;

    localparam logic [WGT_W-1:0] WEIGHT_CAP = WGT_W'(40960);
    localparam logic signed [MAG_W-1:0] MAG_THR_RESET = MAG_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_MAINSHOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAT_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAT_END   = 2'd3;

    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned LN10_Q30 = 64'd2472381919;

    typedef struct packed {
        logic signed [POS_W-1:0]  east;
        logic signed [POS_W-1:0]  north;
        logic signed [POS_W-1:0]  depth;
        logic        [TIME_W-1:0] evt_time;
        logic signed [MAG_W-1:0]  mag;
    } t_event;

    typedef struct packed {
        logic              keep;
        logic [TIME_W-1:0] cov;
        logic [TIME_W-1:0] miss;
    } t_track;

    typedef logic [R2_W-1:0]  t_r2_rom  [ROM_DEPTH];
    typedef logic [DUR_W-1:0] t_dur_rom [ROM_DEPTH];

    // shift-subtract quotient, used only while building the tables
    function automatic longint unsigned div_small(longint unsigned a, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((a >> b) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // floor(10^(e6/1e6) * 2^shift), series for exp in q30
    function automatic longint unsigned pow10_scaled(longint e6, int shift);
        longint k;
        longint unsigned f;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned v;
        bit done;
        if (e6 >= 0) k = e6 / 1000000;
        else k = -((-e6 + 999999) / 1000000);
        f = longint'(e6 - k * 1000000);
        y = f * LN10_Q30 / 1000000;
        sum = Q30_ONE;
        term = Q30_ONE;
        done = 1'b0;
        for (int n = 1; n <= 40; n++) begin
            if (!done) begin
                term = (term * y) >> 30;
                term = div_small(term, 64'(n));
                if (term == 0) done = 1'b1;
                else sum = sum + term;
            end
        end
        if (k >= 0) begin
            for (int i = 0; i < 5; i++) begin
                if (i < k) sum = sum * 10;
            end
            return sum >> (30 - shift);
        end
        v = sum << shift;
        for (int i = 0; i < 20; i++) begin
            if (i < -k) v = v / 10;
        end
        return v >> 30;
    endfunction

    function automatic longint mag_of(int idx);
        return (idx < ROM_DEPTH / 2) ? longint'(idx) : longint'(idx - ROM_DEPTH);
    endfunction

    function automatic t_r2_rom build_r2_rom();
        t_r2_rom rom;
        for (int idx = 0; idx < ROM_DEPTH; idx++) begin
            rom[idx] = R2_W'(pow10_scaled(2 * (1238 * mag_of(idx) + 983000), 16));
        end
        return rom;
    endfunction

    function automatic t_dur_rom build_dur_rom();
        t_dur_rom rom;
        longint m;
        for (int idx = 0; idx < ROM_DEPTH; idx++) begin
            m = mag_of(idx);
            if (m >= 650) rom[idx] = DUR_W'(pow10_scaled(320 * m + 2738900, 10));
            else rom[idx] = DUR_W'(pow10_scaled(5409 * m - 547000, 10));
        end
        return rom;
    endfunction

    localparam t_r2_rom  R2_ROM  = build_r2_rom();
    localparam t_dur_rom DUR_ROM = build_dur_rom();

endpackage

/* rtl/space_time_window_declustering.sv */
// channel  | direction | handshake                 | payload
// input    | in        | i_in_valid / o_in_ready   | east, north, depth, time, magnitude, is_last
// result   | out       | o_out_valid / i_out_ready | event_index, selected, weight, last_result
// config   | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_wr_data
//
// events load one per cycle into the event memory; the last event starts the pass
// pass for n events: track init over n entries, then per event a read, capture and
// table lookup plus, for a mainshock, a sweep over the track memory (one pair per
// cycle) and a pipeline drain; then per result a read, and the divider for a kept
// result below the cap but not for a removed or capped result, plus output wait
// input is not taken during the pass or while results are out
// synchronous active-low reset clears control and config; memories are not cleared
module space_time_window_declustering (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [stwd_pkg::POS_W-1:0]  i_east_pos,
    input  logic signed [stwd_pkg::POS_W-1:0]  i_north_pos,
    input  logic signed [stwd_pkg::POS_W-1:0]  i_depth_pos,
    input  logic        [stwd_pkg::TIME_W-1:0] i_event_time,
    input  logic signed [stwd_pkg::MAG_W-1:0]  i_magnitude,
    input  logic                               i_is_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic        [stwd_pkg::IDX_W-1:0]  o_event_index,
    output logic                               o_selected,
    output logic        [stwd_pkg::WGT_W-1:0]  o_weight,
    output logic                               o_last_result,
    input  logic                               i_cfg_wr_en,
    input  logic [stwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stwd_pkg::CFG_W-1:0]         i_cfg_wr_data
);
    import stwd_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_RD_I, S_CAP_I, S_ROM_I, S_ROW, S_DRAIN,
        S_RD_W, S_WAIT_W, S_DIV, S_OUT
    } t_state;

    localparam int DIV_STEPS = NUM_W;
    localparam int K_W = $clog2(DIV_STEPS + 1);

    t_state r_state;
    logic [CNT_W-1:0] r_cnt, r_i, r_j;

    // config
    logic signed [MAG_W-1:0] r_thr;
    logic                    r_use_depth;
    logic [TIME_W-1:0]       r_start, r_end;

    // mainshock
    logic signed [POS_W-1:0] r_ei, r_ni, r_di;
    logic [TIME_W-1:0]       r_ti;
    logic signed [MAG_W-1:0] r_mi;
    logic [R2_W-1:0]         r_r2;
    logic [DUR_W-1:0]        r_dur;

    // memories
    logic              a_we, b_we;
    logic [ADDR_W-1:0] a_wa, a_ra, b_wa, b_ra;
    t_event            a_wd, a_rd;
    t_track            b_wd, b_rd;

    // pair pipeline
    logic              r1_v, r2_v, r3_v;
    logic [CNT_W-1:0]  r1_j, r2_j, r3_j;
    logic [SQ_W-1:0]   r2_sqe, r2_sqn, r2_sqd;
    logic [TIME_W-1:0] r2_tj;
    t_track            r2_trk, r3_trk;
    logic [D2_W-1:0]   r3_d2;
    logic [TIME_W-1:0] r3_a, r3_b;
    logic              r3_rm;

    // divider and output
    logic [NUM_W-1:0]  r_num;
    logic [TIME_W-1:0] r_rem, r_den;
    logic [K_W-1:0]    r_k;
    logic              r_keep;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_sel, r_out_last;
    logic [WGT_W-1:0]  r_out_w;

    logic in_fire, out_fire, j_last, i_last;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign j_last   = (r_j == r_cnt - CNT_W'(1));
    assign i_last   = (r_i == r_cnt - CNT_W'(1));

    stwd_ram #(.WIDTH($bits(t_event)), .DEPTH(MAX_EVENTS)) u_evt_ram (
        .i_clk(i_clk), .i_wr_en(a_we), .i_wr_addr(a_wa), .i_wr_data(a_wd),
        .i_rd_addr(a_ra), .o_rd_data(a_rd)
    );

    stwd_ram #(.WIDTH($bits(t_track)), .DEPTH(MAX_EVENTS)) u_trk_ram (
        .i_clk(i_clk), .i_wr_en(b_we), .i_wr_addr(b_wa), .i_wr_data(b_wd),
        .i_rd_addr(b_ra), .o_rd_data(b_rd)
    );

    // pair update, last pipeline stage
    logic              p3_in;
    logic [TIME_W:0]   p3_sum;
    logic [TIME_W-1:0] p3_miss, p3_cov;
    always_comb begin
        p3_in   = (r3_d2 <= D2_W'(r_r2));
        p3_sum  = {1'b0, r3_trk.miss} + {1'b0, r3_a - r3_b};
        p3_miss = (r3_a > r3_b) ? (p3_sum[TIME_W] ? '1 : p3_sum[TIME_W-1:0]) : r3_trk.miss;
        p3_cov  = (r3_a > r3_trk.cov) ? r3_a : r3_trk.cov;
    end

    always_comb begin
        a_we = in_fire && (r_cnt < CNT_W'(MAX_EVENTS));
        a_wa = r_cnt[ADDR_W-1:0];
        a_wd = '{east: i_east_pos, north: i_north_pos, depth: i_depth_pos,
                 evt_time: i_event_time, mag: i_magnitude};
        a_ra = (r_state == S_ROW) ? r_j[ADDR_W-1:0] : r_i[ADDR_W-1:0];
        b_ra = r_j[ADDR_W-1:0];
        if (r_state == S_INIT) begin
            b_we = 1'b1;
            b_wa = r_j[ADDR_W-1:0];
            b_wd = '{keep: 1'b1, cov: r_start, miss: '0};
        end else begin
            b_we = r3_v && r3_trk.keep && p3_in;
            b_wa = r3_j[ADDR_W-1:0];
            if (r3_rm) b_wd = '{keep: 1'b0, cov: r3_trk.cov, miss: r3_trk.miss};
            else b_wd = '{keep: 1'b1, cov: p3_cov, miss: p3_miss};
        end
    end

    // first two pipeline stages: squares, then distance sum and time window
    logic signed [POS_W:0]   p1_de, p1_dn, p1_dd;
    logic signed [SQ_W-1:0]  p1_pe, p1_pn, p1_pd;
    logic [TIME_W:0]         p2_end;
    logic [TIME_W-1:0]       p2_dt;
    always_comb begin
        p1_de = {a_rd.east[POS_W-1], a_rd.east} - {r_ei[POS_W-1], r_ei};
        p1_dn = {a_rd.north[POS_W-1], a_rd.north} - {r_ni[POS_W-1], r_ni};
        p1_dd = {a_rd.depth[POS_W-1], a_rd.depth} - {r_di[POS_W-1], r_di};
        p1_pe = p1_de * p1_de;
        p1_pn = p1_dn * p1_dn;
        p1_pd = p1_dd * p1_dd;
        p2_end = {1'b0, r_ti} + (TIME_W + 1)'(r_dur);
        p2_dt  = r2_tj - r_ti;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= (r_state == S_ROW);
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        r1_j   <= r_j;
        r2_j   <= r1_j;
        r3_j   <= r2_j;
        r2_sqe <= unsigned'(p1_pe);
        r2_sqn <= unsigned'(p1_pn);
        r2_sqd <= r_use_depth ? unsigned'(p1_pd) : '0;
        r2_tj  <= a_rd.evt_time;
        r2_trk <= b_rd;
        r3_trk <= r2_trk;
        r3_d2  <= D2_W'(r2_sqe) + D2_W'(r2_sqn) + D2_W'(r2_sqd);
        r3_a   <= (p2_end > {1'b0, r_end}) ? r_end : p2_end[TIME_W-1:0];
        r3_b   <= (r2_trk.cov > r_ti) ? r2_trk.cov : r_ti;
        r3_rm  <= (r2_tj > r_ti) && (p2_dt <= TIME_W'(r_dur)) && (r2_j != r_i);
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= MAG_THR_RESET;
            r_use_depth <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAINSHOCK: r_thr       <= i_cfg_wr_data[MAG_W-1:0];
                CFG_USE_DEPTH: r_use_depth <= i_cfg_wr_data[0];
                CFG_CAT_START: r_start     <= i_cfg_wr_data[TIME_W-1:0];
                CFG_CAT_END:   r_end       <= i_cfg_wr_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // weight divider step and span
    logic [TIME_W:0]   d_trial;
    logic              d_ge;
    logic [TIME_W-1:0] w_span;
    always_comb begin
        d_trial = {r_rem, r_num[NUM_W-1]};
        d_ge    = d_trial >= {1'b0, r_den};
        w_span  = (r_end > r_start) ? r_end - r_start : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_cnt < CNT_W'(MAX_EVENTS)) r_cnt <= r_cnt + CNT_W'(1);
                        if (i_is_last) begin
                            r_j     <= '0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_j <= r_j + CNT_W'(1);
                    if (j_last) begin
                        r_i     <= '0;
                        r_state <= S_RD_I;
                    end
                end
                S_RD_I: r_state <= S_CAP_I;
                S_CAP_I: begin
                    r_ei    <= a_rd.east;
                    r_ni    <= a_rd.north;
                    r_di    <= a_rd.depth;
                    r_ti    <= a_rd.evt_time;
                    r_mi    <= a_rd.mag;
                    r_state <= S_ROM_I;
                end
                S_ROM_I: begin
                    r_r2  <= R2_ROM[unsigned'(r_mi)];
                    r_dur <= DUR_ROM[unsigned'(r_mi)];
                    r_j   <= '0;
                    if (r_mi >= r_thr) begin
                        r_state <= S_ROW;
                    end else if (i_last) begin
                        r_state <= S_RD_W;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_RD_I;
                    end
                end
                S_ROW: begin
                    r_j <= r_j + CNT_W'(1);
                    if (j_last) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r1_v && !r2_v && !r3_v) begin
                        r_j <= '0;
                        if (i_last) begin
                            r_state <= S_RD_W;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_RD_I;
                        end
                    end
                end
                S_RD_W: r_state <= S_WAIT_W;
                S_WAIT_W: begin
                    r_keep     <= b_rd.keep;
                    r_out_idx  <= IDX_W'(r_j);
                    r_out_sel  <= b_rd.keep;
                    r_out_last <= j_last;
                    r_num      <= {w_span, 12'd0};
                    r_den      <= w_span - b_rd.miss;
                    r_rem      <= '0;
                    r_k        <= K_W'(DIV_STEPS);
                    if (!b_rd.keep) begin
                        r_out_w <= '0;
                        r_state <= S_OUT;
                    end else if (b_rd.miss >= w_span) begin
                        r_out_w <= WEIGHT_CAP;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_k == '0) begin
                        r_out_w <= (r_num > NUM_W'(WEIGHT_CAP)) ? WEIGHT_CAP : r_num[WGT_W-1:0];
                        r_state <= S_OUT;
                    end else begin
                        r_rem <= d_ge ? TIME_W'(d_trial - {1'b0, r_den}) : d_trial[TIME_W-1:0];
                        r_num <= {r_num[NUM_W-2:0], d_ge};
                        r_k   <= r_k - K_W'(1);
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        if (j_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_j     <= r_j + CNT_W'(1);
                            r_state <= S_RD_W;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_LOAD);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_event_index = r_out_idx;
    assign o_selected    = r_out_sel && r_keep;
    assign o_weight      = r_out_w;
    assign o_last_result = r_out_last;
endmodule

/* rtl/stwd_ram.sv */
module stwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/stwd_checker.sv */
module stwd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_is_last,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic        [stwd_pkg::IDX_W-1:0]  o_event_index,
    input logic                               o_selected,
    input logic        [stwd_pkg::WGT_W-1:0]  o_weight,
    input logic                               o_last_result
);
    import stwd_pkg::*;

    // no loading while results are out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_weight)
        && $stable(o_event_index) && $stable(o_selected))
        else $error("result changed while stalled");

    // removed events weigh zero, kept events at least one, never above the cap
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_selected ? (o_weight >= 16'd4096 && o_weight <= WEIGHT_CAP)
                                    : (o_weight == '0)))
        else $error("weight out of range");

    // results stream on until the final one
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_result |=> !o_in_ready)
        else $error("input reopened before the final result");

    // a last event starts the pass
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_is_last |=> !o_in_ready)
        else $error("input still ready after the last event");
endmodule

bind space_time_window_declustering stwd_checker u_stwd_checker (.*);

/* dv/space_time_window_declustering_tb.sv */
`timescale 1ns / 100ps

module space_time_window_declustering_tb;
    import stwd_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_EVENTS = 180;
    localparam int  LONG_HOLD   = 6000;
    localparam longint unsigned T_MAX = 64'hFF_FFFF_FFFF;

    typedef enum logic {ROW_CFG, ROW_EVT} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IDX_W-1:0]      cidx;
        logic [CFG_W-1:0]          cdata;
        logic signed [POS_W-1:0]   e;
        logic signed [POS_W-1:0]   n;
        logic signed [POS_W-1:0]   d;
        logic [TIME_W-1:0]         t;
        logic signed [MAG_W-1:0]   m;
        bit                        last;
        bit                        chk;
        bit                        xsel;
        logic [WGT_W-1:0]          xwgt;
    } t_row;

    typedef struct {
        logic [IDX_W-1:0] idx;
        bit               sel;
        logic [WGT_W-1:0] wgt;
        bit               lst;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_east_pos = '0;
    logic signed [POS_W-1:0] i_north_pos = '0;
    logic signed [POS_W-1:0] i_depth_pos = '0;
    logic [TIME_W-1:0]       i_event_time = '0;
    logic signed [MAG_W-1:0] i_magnitude = '0;
    logic                    i_is_last = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [IDX_W-1:0]        o_event_index;
    logic                    o_selected;
    logic [WGT_W-1:0]        o_weight;
    logic                    o_last_result;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_wr_data = '0;

    space_time_window_declustering dut (.*);

    // catalog copy and configuration
    logic signed [POS_W-1:0] cat_e [MAX_EVENTS];
    logic signed [POS_W-1:0] cat_n [MAX_EVENTS];
    logic signed [POS_W-1:0] cat_d [MAX_EVENTS];
    longint unsigned         cat_t [MAX_EVENTS];
    logic signed [MAG_W-1:0] cat_m [MAX_EVENTS];
    int                      cat_count = 0;
    longint                  thr_mag = 500;
    bit                      depth_on = 1'b0;
    longint unsigned         cat_start = 0;
    longint unsigned         cat_end = 0;

    t_result weight_q[$];
    t_result fresh_q[$];
    t_row    rows[$];

    int  errors = 0;
    int  n_checked = 0;
    int  n_loaded = 0;
    int  n_catalogs = 0;
    int  n_cfg = 0;
    bit  quiet = 1'b0;
    bit  long_hold = 1'b0;
    longint cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("space_time_window_declustering verification failed");
            $finish;
        end
    end

    // floor(10^(e/1e6) * 2^sh) in integers
    function automatic longint unsigned pow10_fix(longint e, int sh);
        longint k;
        longint unsigned fr, y, acc, t, v;
        longint unsigned n;
        k = e / 1000000;
        if (e < 0 && k * 1000000 != e) k = k - 1;
        fr = longint'(e - k * 1000000);
        y = fr * LN10_Q30 / 1000000;
        acc = Q30_ONE;
        t = Q30_ONE;
        n = 1;
        while (n <= 40) begin
            t = (t * y) >> 30;
            t = t / n;
            if (t == 0) break;
            acc = acc + t;
            n++;
        end
        if (k >= 0) begin
            repeat (k) acc = acc * 10;
            return acc >> (30 - sh);
        end
        v = acc << sh;
        repeat (-k) v = v / 10;
        return v >> 30;
    endfunction

    function automatic longint unsigned sq_diff(longint a, longint b);
        longint dd;
        dd = a - b;
        if (dd < 0) dd = -dd;
        return longint'(dd) * longint'(dd);
    endfunction

    // declustering pass over the stored catalog, results into fresh_q
    task automatic decluster();
        bit              keep [MAX_EVENTS];
        longint unsigned cov [MAX_EVENTS];
        longint unsigned miss [MAX_EVENTS];
        longint          m;
        longint unsigned r2, dur, ti, tj, a, b, d2, span, w;
        t_result         r;
        for (int j = 0; j < cat_count; j++) begin
            keep[j] = 1'b1;
            cov[j] = cat_start;
            miss[j] = 0;
        end
        for (int i = 0; i < cat_count; i++) begin
            m = longint'(cat_m[i]);
            if (m < thr_mag) continue;
            r2 = pow10_fix(2 * (1238 * m + 983000), 16);
            if (m >= 650) dur = pow10_fix(320 * m + 2738900, 10);
            else dur = pow10_fix(5409 * m - 547000, 10);
            ti = cat_t[i];
            for (int j = 0; j < cat_count; j++) begin
                if (!keep[j]) continue;
                d2 = sq_diff(cat_e[j], cat_e[i]) + sq_diff(cat_n[j], cat_n[i]);
                if (depth_on) d2 = d2 + sq_diff(cat_d[j], cat_d[i]);
                if (d2 > r2) continue;
                tj = cat_t[j];
                if (tj > ti && tj - ti <= dur && j != i) begin
                    keep[j] = 1'b0;
                end else begin
                    a = ti + dur;
                    if (a > cat_end) a = cat_end;
                    b = (cov[j] > ti) ? cov[j] : ti;
                    if (a > b) begin
                        miss[j] = miss[j] + (a - b);
                        if (miss[j] > T_MAX) miss[j] = T_MAX;
                    end
                    if (a > cov[j]) cov[j] = a;
                end
            end
        end
        span = (cat_end > cat_start) ? cat_end - cat_start : 0;
        for (int j = 0; j < cat_count; j++) begin
            if (!keep[j]) w = 0;
            else if (miss[j] >= span) w = 40960;
            else begin
                w = (span << 12) / (span - miss[j]);
                if (w > 40960) w = 40960;
            end
            r.idx = IDX_W'(j);
            r.sel = keep[j];
            r.wgt = WGT_W'(w);
            r.lst = (j + 1 == cat_count);
            fresh_q.push_back(r);
        end
        cat_count = 0;
    endtask

    task automatic load_event(t_row ev);
        if (cat_count < MAX_EVENTS) begin
            cat_e[cat_count] = ev.e;
            cat_n[cat_count] = ev.n;
            cat_d[cat_count] = ev.d;
            cat_t[cat_count] = ev.t;
            cat_m[cat_count] = ev.m;
            cat_count++;
        end
        if (ev.last) begin
            fresh_q.delete();
            decluster();
            n_catalogs++;
            if (ev.chk) begin
                // single-event catalog, result known up front
                weight_q.push_back('{IDX_W'(0), ev.xsel, ev.xwgt, 1'b1});
            end else begin
                foreach (fresh_q[k]) weight_q.push_back(fresh_q[k]);
            end
        end
    endtask

    // called just after a rising edge
    task automatic send_event(t_row ev);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_east_pos   <= ev.e;
        i_north_pos  <= ev.n;
        i_depth_pos  <= ev.d;
        i_event_time <= ev.t;
        i_magnitude  <= ev.m;
        i_is_last    <= ev.last;
        do @(posedge i_clk); while (!o_in_ready);
        n_loaded++;
        load_event(ev);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (weight_q.size() != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_MAINSHOCK: thr_mag = longint'($signed(data[MAG_W-1:0]));
            CFG_USE_DEPTH: depth_on = data[0];
            CFG_CAT_START: cat_start = data;
            CFG_CAT_END:   cat_end = data;
            default: ;
        endcase
    endtask

    function automatic t_row evt(longint e, longint n, longint d, longint unsigned t, int m,
                                 bit last, bit chk = 0, bit xsel = 0, int xwgt = 0);
        t_row r;
        r.kind = ROW_EVT;
        r.cidx = '0;
        r.cdata = '0;
        r.e = POS_W'(e);
        r.n = POS_W'(n);
        r.d = POS_W'(d);
        r.t = TIME_W'(t);
        r.m = MAG_W'(m);
        r.last = last;
        r.chk = chk;
        r.xsel = xsel;
        r.xwgt = WGT_W'(xwgt);
        return r;
    endfunction

    function automatic t_row cfg(logic [CFG_IDX_W-1:0] idx, longint unsigned data);
        t_row r;
        r = evt(0, 0, 0, 0, 0, 0);
        r.kind = ROW_CFG;
        r.cidx = idx;
        r.cdata = CFG_W'(data);
        return r;
    endfunction

    // receiver: random stalls, one long hold-off, none at the end
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (weight_q.size() == 0) begin
                $error("unexpected result transaction: index %0d", o_event_index);
                errors++;
            end else begin
                x = weight_q.pop_front();
                n_checked++;
                if (o_event_index !== x.idx) begin
                    $error("event_index: expected %0d actual %0d", x.idx, o_event_index);
                    errors++;
                end
                if (o_selected !== x.sel) begin
                    $error("selected: expected %0d actual %0d", x.sel, o_selected);
                    errors++;
                end
                if (o_weight !== x.wgt) begin
                    $error("weight: expected %0d actual %0d", x.wgt, o_weight);
                    errors++;
                end
                if (o_last_result !== x.lst) begin
                    $error("last_result: expected %0d actual %0d", x.lst, o_last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row            ev;
        int              sent, n_ev, n_cat;
        longint          ce, cn, cd;
        longint unsigned tnow, base;
        bit              wide;

        // directed catalogs
        rows.push_back(evt(8388607, -8388608, 0, 0, 1000, 1, 1, 1, 40960)); // zero span
        rows.push_back(cfg(CFG_CAT_END, 1000000));
        rows.push_back(evt(100, 100, 0, 500, 300, 0));          // foreshock near
        rows.push_back(evt(0, 0, 0, 1000, 700, 0));             // large mainshock
        rows.push_back(evt(256, 0, 5000, 2000, 200, 0));        // aftershock
        rows.push_back(evt(8388607, 8388607, 0, 3000, 600, 0)); // far, smaller law
        rows.push_back(evt(-8388608, -8388608, -8388608, 999000, -200, 0));
        rows.push_back(evt(0, 0, 0, 1000000, 1000, 1));         // window past end
        rows.push_back(cfg(CFG_USE_DEPTH, 1));
        rows.push_back(cfg(CFG_CAT_START, 2000000));            // end before start
        rows.push_back(evt(0, 0, 8388607, 2000000, 500, 1, 1, 1, 40960));
        rows.push_back(cfg(CFG_CAT_START, 0));
        rows.push_back(cfg(CFG_CAT_END, T_MAX));
        rows.push_back(cfg(CFG_MAINSHOCK, 40'(-200)));
        rows.push_back(evt(10, 20, 30, T_MAX - 775, 1000, 0));
        rows.push_back(evt(10, 20, 30, T_MAX - 775, 400, 0));   // same time
        rows.push_back(evt(-10, 20, -8388608, T_MAX - 100, 650, 0));
        rows.push_back(evt(10, -20, 30, T_MAX, -200, 1));
        rows.push_back(cfg(CFG_MAINSHOCK, 1000));
        rows.push_back(evt(0, 0, 0, 5, 999, 0));
        rows.push_back(evt(0, 0, 0, 6, 1000, 1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                settle();
                cfg_write(rows[r].cidx, rows[r].cdata);
            end else begin
                send_event(rows[r]);
            end
        end

        // random catalogs, clustered in time and mostly in space
        sent = 0;
        n_cat = 0;
        while (sent < RAND_EVENTS) begin
            if (n_cat != 4 && $urandom_range(0, 2) == 0) begin
                settle();
                cfg_write(CFG_MAINSHOCK, 40'($signed(11'($urandom_range(0, 1200) - 200))));
                cfg_write(CFG_USE_DEPTH, CFG_W'($urandom_range(0, 1)));
                base = {$urandom, $urandom} & T_MAX;
                if (base > T_MAX - 64'd20000000) base = base - 64'd20000000;
                case ($urandom_range(0, 5))
                    0: begin
                        cfg_write(CFG_CAT_START, CFG_W'(0));
                        cfg_write(CFG_CAT_END, CFG_W'(T_MAX));
                    end
                    1: begin
                        cfg_write(CFG_CAT_START, CFG_W'(base + 100000));
                        cfg_write(CFG_CAT_END, CFG_W'(base));
                    end
                    default: begin
                        cfg_write(CFG_CAT_START, CFG_W'(base));
                        cfg_write(CFG_CAT_END, CFG_W'(base + $urandom_range(200000, 4000000)));
                    end
                endcase
            end
            n_ev = (n_cat == 3) ? MAX_EVENTS + 2 : $urandom_range(1, 12);
            wide = ($urandom_range(0, 4) == 0);
            ce = longint'($signed(24'($urandom)));
            cn = longint'($signed(24'($urandom)));
            cd = longint'($signed(24'($urandom)));
            tnow = (cat_start > 64'd20000) ? cat_start - $urandom_range(0, 20000)
                                           : cat_start;
            if (tnow > T_MAX - 64'd10000000) tnow = T_MAX - 64'd10000000;
            for (int k = 0; k < n_ev; k++) begin
                if (wide) begin
                    ev = evt(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                             longint'($signed(24'($urandom))), tnow,
                             $urandom_range(0, 1200) - 200, k == n_ev - 1);
                end else begin
                    ev = evt(ce + $urandom_range(0, 40000) - 20000,
                             cn + $urandom_range(0, 40000) - 20000,
                             cd + $urandom_range(0, 40000) - 20000, tnow,
                             $urandom_range(0, 1200) - 200, k == n_ev - 1);
                end
                send_event(ev);
                tnow = tnow + $urandom_range(0, 60000);
                sent++;
                if (sent > RAND_EVENTS - 30) quiet = 1'b1;
            end
            // next catalog is offered while results of the full one are held back
            if (n_cat == 3) long_hold = 1'b1;
            n_cat++;
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (weight_q.size() != 0);
        repeat (200) @(posedge i_clk);

        $display("%0d events in %0d catalogs, %0d register writes, %0d results checked",
                 n_loaded, n_catalogs, n_cfg, n_checked);
        if (errors == 0 && weight_q.size() == 0) begin
            $display("space_time_window_declustering verification clean");
        end else begin
            $display("space_time_window_declustering verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/stwd_pkg.sv
rtl/stwd_ram.sv
rtl/space_time_window_declustering.sv
rtl/stwd_checker.sv
dv/space_time_window_declustering_tb.sv
